// ===== design/label_region_mean_map_top_macros.svh =====
// Assertion macros for the label region mean map block.
// Used by label_region_mean_map_top.sv; no other dependencies.
`ifndef LABEL_REGION_MEAN_MAP_TOP_MACROS_SVH
`define LABEL_REGION_MEAN_MAP_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define LRMM_ASSERT_SAME(name, ck, rs, ante, cons, msg) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);
`define LRMM_ASSERT_NEXT(name, ck, rs, ante, cons, msg) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);
`else
`define LRMM_ASSERT_SAME(name, ck, rs, ante, cons, msg)
`define LRMM_ASSERT_NEXT(name, ck, rs, ante, cons, msg)
`endif

`endif

// ===== design/lrmm_pkg.sv =====
// Types and constants for the label region mean map block.
// No dependencies; used by every module of the block.
package lrmm_pkg;

  localparam int LABEL_COUNT = 1024;
  localparam int LABEL_W     = 10;
  localparam int CUE_W       = 8;
  localparam int ADD_W       = CUE_W + 1;
  localparam int SUM_W       = 30;
  localparam int CNT_W       = 21;
  localparam int FRAC_BITS   = 8;
  localparam int MEAN_W      = 17;
  localparam int DIVIDEND_W  = SUM_W + FRAC_BITS;
  localparam int STEP_W      = $clog2(DIVIDEND_W);

  localparam logic [SUM_W-1:0]   SUM_MAX    = {SUM_W{1'b1}};
  localparam logic [CNT_W-1:0]   CNT_MAX    = {CNT_W{1'b1}};
  localparam logic [MEAN_W-1:0]  MEAN_MAX   = MEAN_W'(130560);
  localparam logic [LABEL_W-1:0] LAST_LABEL = LABEL_W'(LABEL_COUNT - 1);
  localparam logic [STEP_W-1:0]  LAST_STEP  = STEP_W'(DIVIDEND_W - 1);

  localparam logic [1:0] CMD_ACC   = 2'd0;
  localparam logic [1:0] CMD_LOOK  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]         command;
    logic [LABEL_W-1:0] pixel_label;
    logic [CUE_W-1:0]   fg_cue;
    logic [CUE_W-1:0]   bk_cue;
  } req_t;

  typedef struct packed {
    logic [MEAN_W-1:0] mean_value;
    logic              saturated;
  } res_t;

  typedef struct packed {
    logic             sat;
    logic [CNT_W-1:0] count;
    logic [SUM_W-1:0] sum;
  } entry_t;

  typedef struct packed {
    logic               valid;
    logic               lookup;
    logic [LABEL_W-1:0] label;
    logic [ADD_W-1:0]   add;
  } store_cmd_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } lookup_t;

  typedef struct packed {
    logic                  valid;
    logic [DIVIDEND_W-1:0] dividend;
    logic [CNT_W-1:0]      divisor;
    logic                  sat;
  } div_req_t;

endpackage

// ===== design/label_region_mean_map_top.sv =====
// Top level of the label region mean map block: handshake and command decode.
// Depends on lrmm_pkg, lrmm_store, lrmm_div and the assertion macro header.
//
// Per-label mean of summed foreground and background cues. A request is taken
// at a clock edge with start high and busy low. Accumulate requests are taken
// one per cycle back to back while busy is low; a read-modify-write on the
// label memory with forwarding of the previous write keeps repeated labels
// exact. A lookup keeps busy high through the memory read and the bit-serial
// divider, and its result is on done/result when the divider finishes; the next
// request may be taken in the cycle done is high. done is a one-cycle strobe
// that cannot be held off, so result must be captured when done is high. A
// clear sweeps the label memory one entry per cycle with busy high; the same
// sweep runs after reset.
`include "label_region_mean_map_top_macros.svh"

module label_region_mean_map_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  lrmm_pkg::req_t request,
  output logic           done,
  output lrmm_pkg::res_t result
);

  logic                 accept;
  logic                 clearing;
  logic                 div_busy;
  lrmm_pkg::store_cmd_t store_cmd;
  lrmm_pkg::lookup_t    look;
  lrmm_pkg::div_req_t   div_req;

  assign busy   = clearing | look.valid | div_busy;
  assign accept = start & ~busy;

  assign store_cmd.valid  = accept && ((request.command == lrmm_pkg::CMD_ACC) ||
                                       (request.command == lrmm_pkg::CMD_LOOK));
  assign store_cmd.lookup = request.command == lrmm_pkg::CMD_LOOK;
  assign store_cmd.label  = request.pixel_label;
  assign store_cmd.add    = lrmm_pkg::ADD_W'(request.fg_cue) + lrmm_pkg::ADD_W'(request.bk_cue);

  assign div_req.valid    = look.valid;
  assign div_req.dividend = {look.entry.sum, {lrmm_pkg::FRAC_BITS{1'b0}}};
  assign div_req.divisor  = (look.entry.count == '0) ? lrmm_pkg::CNT_W'(1) : look.entry.count;
  assign div_req.sat      = look.entry.sat;

  lrmm_store u_store (
    .clk         (clk),
    .rst         (rst),
    .cmd         (store_cmd),
    .clear_start (accept && (request.command == lrmm_pkg::CMD_CLEAR)),
    .look        (look),
    .clearing    (clearing)
  );

  lrmm_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .busy (div_busy),
    .done (done),
    .res  (result)
  );

  `LRMM_ASSERT_NEXT(a_lookup_starts_div, clk, rst, look.valid, div_busy, "no divide")
  `LRMM_ASSERT_SAME(a_done_after_div, clk, rst, done, $past(div_busy) && !div_busy, "stray done")
  `LRMM_ASSERT_SAME(a_no_accept_in_sweep, clk, rst, clearing, !accept && !look.valid, "in clear")

endmodule

// ===== design/lrmm_store.sv =====
// Per-label sum/count/flag memory with read-modify-write update and clear sweep.
// Depends on lrmm_pkg.
module lrmm_store (
  input  logic                 clk,
  input  logic                 rst,
  input  lrmm_pkg::store_cmd_t cmd,
  input  logic                 clear_start,
  output lrmm_pkg::lookup_t    look,
  output logic                 clearing
);

  lrmm_pkg::entry_t mem [0:lrmm_pkg::LABEL_COUNT-1];

  logic                         s1_valid;
  logic                         s1_lookup;
  logic [lrmm_pkg::LABEL_W-1:0] s1_label;
  logic [lrmm_pkg::ADD_W-1:0]   s1_add;
  lrmm_pkg::entry_t             rdata;

  logic                         fwd_valid;
  logic [lrmm_pkg::LABEL_W-1:0] fwd_label;
  lrmm_pkg::entry_t             fwd_entry;

  logic [lrmm_pkg::LABEL_W-1:0] clr_cnt;

  lrmm_pkg::entry_t             cur;
  lrmm_pkg::entry_t             upd;
  logic [lrmm_pkg::SUM_W:0]     sum_ext;
  logic                         sum_hit;
  logic                         cnt_hit;
  logic                         acc_wr;
  logic                         wr_en;
  logic [lrmm_pkg::LABEL_W-1:0] wr_addr;
  lrmm_pkg::entry_t             wr_data;

  // last edge's write has not reached the read data yet
  assign cur = (fwd_valid && (fwd_label == s1_label)) ? fwd_entry : rdata;

  always_comb begin
    sum_ext = (lrmm_pkg::SUM_W + 1)'(cur.sum) + (lrmm_pkg::SUM_W + 1)'(s1_add);
    sum_hit = sum_ext >= (lrmm_pkg::SUM_W + 1)'(lrmm_pkg::SUM_MAX);
    upd.sum = sum_hit ? lrmm_pkg::SUM_MAX : sum_ext[lrmm_pkg::SUM_W-1:0];
    upd.count = (cur.count == lrmm_pkg::CNT_MAX) ? lrmm_pkg::CNT_MAX
                                                  : cur.count + lrmm_pkg::CNT_W'(1);
    cnt_hit = upd.count == lrmm_pkg::CNT_MAX;
    upd.sat = cur.sat | sum_hit | cnt_hit;
  end

  assign acc_wr  = s1_valid & ~s1_lookup;
  assign wr_en   = acc_wr | clearing;
  assign wr_addr = clearing ? clr_cnt : s1_label;
  assign wr_data = clearing ? '0 : upd;

  assign look.valid = s1_valid & s1_lookup;
  assign look.entry = cur;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.valid) begin
      rdata <= mem[cmd.label];
    end
  end

  always_ff @(posedge clk) begin
    s1_lookup <= cmd.lookup;
    s1_label  <= cmd.label;
    s1_add    <= cmd.add;
    fwd_label <= s1_label;
    fwd_entry <= upd;
    if (rst) begin
      s1_valid  <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      s1_valid  <= cmd.valid;
      fwd_valid <= acc_wr & ~clearing;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear_start) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + lrmm_pkg::LABEL_W'(1);
      if (clr_cnt == lrmm_pkg::LAST_LABEL) begin
        clearing <= 1'b0;
      end
    end
  end

endmodule

// ===== design/lrmm_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle, with mean clamp.
// Depends on lrmm_pkg.
module lrmm_div (
  input  logic               clk,
  input  logic               rst,
  input  lrmm_pkg::div_req_t req,
  output logic               busy,
  output logic               done,
  output lrmm_pkg::res_t     res
);

  logic [lrmm_pkg::STEP_W-1:0]     step;
  logic [lrmm_pkg::CNT_W-1:0]      rem;
  logic [lrmm_pkg::CNT_W-1:0]      den;
  logic [lrmm_pkg::DIVIDEND_W-1:0] quo;
  logic                            sat;

  logic [lrmm_pkg::CNT_W:0]        trial;
  logic                            fits;

  assign trial = {rem, quo[lrmm_pkg::DIVIDEND_W-1]};
  assign fits  = trial >= {1'b0, den};

  assign res.mean_value = (quo > lrmm_pkg::DIVIDEND_W'(lrmm_pkg::MEAN_MAX))
                          ? lrmm_pkg::MEAN_MAX : quo[lrmm_pkg::MEAN_W-1:0];
  assign res.saturated  = sat;

  always_ff @(posedge clk) begin
    if (req.valid) begin
      rem <= '0;
      den <= req.divisor;
      quo <= req.dividend;
      sat <= req.sat;
    end else if (busy) begin
      rem <= fits ? lrmm_pkg::CNT_W'(trial - {1'b0, den}) : trial[lrmm_pkg::CNT_W-1:0];
      quo <= {quo[lrmm_pkg::DIVIDEND_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= busy && (step == lrmm_pkg::LAST_STEP);
      if (req.valid) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + lrmm_pkg::STEP_W'(1);
        if (step == lrmm_pkg::LAST_STEP) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== sim/testbench.sv =====
// Testbench for label_region_mean_map_top: directed table, then random bursts.
// Expected lookup means come from the directed table where given, else from a cycle-free label accumulator model here.
// Depends on lrmm_pkg and the design sources.
`timescale 1ns / 1ps

module testbench;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 620;
  localparam int CYCLE_LIMIT  = 3000000;
  localparam int TAIL_CYCLES  = 60;

  typedef struct {
    lrmm_pkg::req_t req;
    bit             typed;
    lrmm_pkg::res_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  lrmm_pkg::req_t request = '0;
  logic done;
  lrmm_pkg::res_t result;

  logic [lrmm_pkg::SUM_W-1:0] sum_mem [lrmm_pkg::LABEL_COUNT];
  logic [lrmm_pkg::CNT_W-1:0] cnt_mem [lrmm_pkg::LABEL_COUNT];
  logic                       sat_mem [lrmm_pkg::LABEL_COUNT];

  lrmm_pkg::res_t pending_means [$];
  stim_row_t      directed [$];
  int             mismatches = 0;
  int             cycles = 0;
  int             burst_left = 0;

  label_region_mean_map_top dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d lookups outstanding", cycles,
               pending_means.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic void clear_labels();
    for (int k = 0; k < lrmm_pkg::LABEL_COUNT; k++) begin
      sum_mem[k] = '0;
      cnt_mem[k] = '0;
      sat_mem[k] = 1'b0;
    end
  endfunction

  // Applies one request to the label store; returns the lookup result.
  function automatic lrmm_pkg::res_t cue_mean_step(lrmm_pkg::req_t r);
    lrmm_pkg::res_t             res;
    int                         k;
    logic [lrmm_pkg::ADD_W-1:0] add;
    logic [63:0]                num;
    logic [63:0]                den;
    logic [63:0]                q;
    res = '0;
    k = int'(r.pixel_label);
    if (r.command == lrmm_pkg::CMD_ACC) begin
      add = lrmm_pkg::ADD_W'(r.fg_cue) + lrmm_pkg::ADD_W'(r.bk_cue);
      if (sum_mem[k] > lrmm_pkg::SUM_MAX - lrmm_pkg::SUM_W'(add)) begin
        sum_mem[k] = lrmm_pkg::SUM_MAX;
        sat_mem[k] = 1'b1;
      end else begin
        sum_mem[k] = sum_mem[k] + lrmm_pkg::SUM_W'(add);
        if (sum_mem[k] == lrmm_pkg::SUM_MAX) sat_mem[k] = 1'b1;
      end
      if (cnt_mem[k] >= lrmm_pkg::CNT_MAX) begin
        cnt_mem[k] = lrmm_pkg::CNT_MAX;
        sat_mem[k] = 1'b1;
      end else begin
        cnt_mem[k] = cnt_mem[k] + lrmm_pkg::CNT_W'(1);
        if (cnt_mem[k] == lrmm_pkg::CNT_MAX) sat_mem[k] = 1'b1;
      end
    end else if (r.command == lrmm_pkg::CMD_LOOK) begin
      num = 64'(sum_mem[k]) << lrmm_pkg::FRAC_BITS;
      den = (cnt_mem[k] == '0) ? 64'd1 : 64'(cnt_mem[k]);
      q = num / den;
      if (q > 64'(lrmm_pkg::MEAN_MAX)) q = 64'(lrmm_pkg::MEAN_MAX);
      res.mean_value = lrmm_pkg::MEAN_W'(q);
      res.saturated  = sat_mem[k];
    end else if (r.command == lrmm_pkg::CMD_CLEAR) begin
      clear_labels();
    end
    return res;
  endfunction

  function automatic stim_row_t stim_row(logic [1:0] cmd, int lab, int fg, int bk,
                                         bit typed, int mean, bit sat);
    stim_row_t row;
    row.req.command     = cmd;
    row.req.pixel_label = lrmm_pkg::LABEL_W'(lab);
    row.req.fg_cue      = lrmm_pkg::CUE_W'(fg);
    row.req.bk_cue      = lrmm_pkg::CUE_W'(bk);
    row.typed           = typed;
    row.want.mean_value = lrmm_pkg::MEAN_W'(mean);
    row.want.saturated  = sat;
    return row;
  endfunction

  // Drives one request in sender bursts; records the expectation on acceptance.
  task automatic send_request(lrmm_pkg::req_t r, bit typed, lrmm_pkg::res_t want);
    int             gap;
    int             pick;
    lrmm_pkg::res_t pred;
    if (burst_left == 0) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) gap = 0;
      else if (pick < 80) gap = $urandom_range(1, 6);
      else gap = $urandom_range(7, 48);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start   <= 1'b1;
    request <= r;
    do @(posedge clk); while (busy);
    pred = cue_mean_step(r);
    if (r.command == lrmm_pkg::CMD_LOOK) pending_means.push_back(typed ? want : pred);
  endtask

  task automatic drain_lookups();
    start <= 1'b0;
    do @(posedge clk); while (pending_means.size() != 0);
    burst_left = 0;
  endtask

  always @(posedge clk) begin
    lrmm_pkg::res_t want;
    if (!rst && done) begin
      if (pending_means.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: mean=%0d sat=%0b", result.mean_value,
                   result.saturated);
      end else begin
        want = pending_means.pop_front();
        if (result.mean_value !== want.mean_value ||
            result.saturated !== want.saturated) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected mean=%0d sat=%0b, got mean=%0d sat=%0b",
                     want.mean_value, want.saturated, result.mean_value,
                     result.saturated);
        end
      end
    end
  end

  initial begin
    lrmm_pkg::req_t r;
    int             counted;
    int             pick;
    int             hot_base;
    bit             drained;

    clear_labels();
    // empty labels, full-scale and zero cues, ignored cue fields, unused command, clear
    directed.push_back(stim_row(lrmm_pkg::CMD_LOOK,  0,    255, 255, 1, 0,      0));
    directed.push_back(stim_row(lrmm_pkg::CMD_LOOK,  1023, 0,   0,   1, 0,      0));
    directed.push_back(stim_row(lrmm_pkg::CMD_ACC,   0,    255, 255, 0, 0,      0));
    directed.push_back(stim_row(lrmm_pkg::CMD_LOOK,  0,    0,   0,   1, 130560, 0));
    directed.push_back(stim_row(lrmm_pkg::CMD_ACC,   0,    0,   0,   0, 0,      0));
    directed.push_back(stim_row(lrmm_pkg::CMD_LOOK,  0,    170, 85,  1, 65280,  0));
    directed.push_back(stim_row(lrmm_pkg::CMD_ACC,   1023, 0,   0,   0, 0,      0));
    directed.push_back(stim_row(lrmm_pkg::CMD_LOOK,  1023, 0,   0,   1, 0,      0));
    directed.push_back(stim_row(lrmm_pkg::CMD_ACC,   1023, 1,   0,   0, 0,      0));
    directed.push_back(stim_row(lrmm_pkg::CMD_LOOK,  1023, 0,   0,   1, 128,    0));
    directed.push_back(stim_row(lrmm_pkg::CMD_ACC,   512,  170, 85,  0, 0,      0));
    directed.push_back(stim_row(lrmm_pkg::CMD_ACC,   512,  85,  170, 0, 0,      0));
    directed.push_back(stim_row(lrmm_pkg::CMD_ACC,   512,  1,   2,   0, 0,      0));
    directed.push_back(stim_row(lrmm_pkg::CMD_LOOK,  512,  0,   0,   0, 0,      0));
    directed.push_back(stim_row(CMD_UNUSED,          512,  255, 255, 0, 0,      0));
    directed.push_back(stim_row(lrmm_pkg::CMD_LOOK,  512,  255, 0,   0, 0,      0));
    directed.push_back(stim_row(lrmm_pkg::CMD_ACC,   341,  255, 0,   0, 0,      0));
    directed.push_back(stim_row(lrmm_pkg::CMD_ACC,   682,  0,   255, 0, 0,      0));
    directed.push_back(stim_row(lrmm_pkg::CMD_LOOK,  341,  0,   0,   0, 0,      0));
    directed.push_back(stim_row(lrmm_pkg::CMD_LOOK,  682,  0,   0,   0, 0,      0));
    directed.push_back(stim_row(lrmm_pkg::CMD_CLEAR, 0,    255, 255, 0, 0,      0));
    directed.push_back(stim_row(lrmm_pkg::CMD_LOOK,  0,    0,   0,   1, 0,      0));
    directed.push_back(stim_row(lrmm_pkg::CMD_LOOK,  512,  0,   0,   1, 0,      0));
    directed.push_back(stim_row(lrmm_pkg::CMD_LOOK,  1023, 0,   0,   1, 0,      0));

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) send_request(directed[i].req, directed[i].typed, directed[i].want);
    drain_lookups();

    counted  = 0;
    drained  = 1'b0;
    hot_base = $urandom_range(0, lrmm_pkg::LABEL_COUNT - 8);
    while (counted < RANDOM_ITEMS) begin
      if (counted % 100 == 99) hot_base = $urandom_range(0, lrmm_pkg::LABEL_COUNT - 8);
      if (!drained && counted >= RANDOM_ITEMS / 2) begin
        drain_lookups();
        drained = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (pick < 2) r.command = lrmm_pkg::CMD_CLEAR;
      else if (pick < 4) r.command = CMD_UNUSED;
      else if (pick < 36) r.command = lrmm_pkg::CMD_LOOK;
      else r.command = lrmm_pkg::CMD_ACC;
      if ($urandom_range(0, 3) == 0)
        r.pixel_label = lrmm_pkg::LABEL_W'($urandom_range(0, 1023));
      else r.pixel_label = lrmm_pkg::LABEL_W'(hot_base + $urandom_range(0, 7));
      r.fg_cue = lrmm_pkg::CUE_W'($urandom_range(0, 255));
      r.bk_cue = lrmm_pkg::CUE_W'($urandom_range(0, 255));
      send_request(r, 1'b0, '0);
      if (r.command != CMD_UNUSED) counted++;
    end

    start <= 1'b0;
    do @(posedge clk); while (pending_means.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_means.size() != 0) mismatches++;

    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== label_region_mean_map_top.f =====
+incdir+design
design/lrmm_pkg.sv
design/lrmm_store.sv
design/lrmm_div.sv
design/label_region_mean_map_top.sv
sim/testbench.sv
